[hw/rtl/ttp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_pkg: shared types, constants and code tables
// Action codes, queue command word, GOST code table and parity helper for the
// text to tape frame generator.
// ----------------------------------------------------------------------------
package ttp_pkg;

    // card geometry
    localparam int CARD_COLUMNS = 120;
    localparam int COL_W        = 7;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // fixed frame values
    localparam logic [7:0] FRAME_BLANK  = 8'h00;
    localparam logic [7:0] FRAME_DECK   = 8'h80;
    localparam logic [6:0] GOST_UNKNOWN = 7'o17;
    localparam int         DECK_STRIDE  = 5;

    // input action codes
    typedef enum logic [1:0] {
        ACT_BYTE      = 2'd0,
        ACT_END       = 2'd1,
        ACT_MOTOR_OFF = 2'd2,
        ACT_MOTOR_ON  = 2'd3
    } action_t;

    // one queued job: a single run, or the whole end-of-deck pattern
    typedef struct packed {
        logic       deck;
        logic [7:0] frame;
        logic [6:0] rep;
    } cmd_t;

    // gost codes for code points 0x20..0x7f
    localparam logic [6:0] ASCII_GOST [0:95] = '{
        7'o17,  7'o133, 7'o134, 7'o34,  7'o127, 7'o126, 7'o121, 7'o33,
        7'o22,  7'o23,  7'o31,  7'o12,  7'o15,  7'o13,  7'o16,  7'o14,
        7'o00,  7'o01,  7'o02,  7'o03,  7'o04,  7'o05,  7'o06,  7'o07,
        7'o10,  7'o11,  7'o37,  7'o26,  7'o35,  7'o25,  7'o36,  7'o136,
        7'o21,  7'o40,  7'o42,  7'o61,  7'o77,  7'o45,  7'o100, 7'o101,
        7'o55,  7'o102, 7'o103, 7'o52,  7'o104, 7'o54,  7'o105, 7'o56,
        7'o60,  7'o106, 7'o107, 7'o110, 7'o62,  7'o111, 7'o112, 7'o113,
        7'o65,  7'o63,  7'o114, 7'o27,  7'o17,  7'o30,  7'o115, 7'o132,
        7'o32,  7'o40,  7'o42,  7'o61,  7'o77,  7'o45,  7'o100, 7'o101,
        7'o55,  7'o102, 7'o103, 7'o52,  7'o104, 7'o54,  7'o105, 7'o56,
        7'o60,  7'o106, 7'o107, 7'o110, 7'o62,  7'o111, 7'o112, 7'o113,
        7'o65,  7'o63,  7'o114, 7'o17,  7'o130, 7'o17,  7'o123, 7'o17
    };

    // code point to 7-bit gost code
    function automatic logic [6:0] to_gost(input logic [15:0] cp);
        logic [15:0] off;
        logic [4:0]  k;
        logic [6:0]  code;
        off  = cp - 16'h0410;
        k    = off[4:0];
        code = GOST_UNKNOWN;
        if (cp >= 16'h0020 && cp <= 16'h007F) begin
            code = ASCII_GOST[cp[6:0] - 7'h20];
        end else if (cp >= 16'h0410 && cp <= 16'h044F) begin
            // upper and lower cyrillic fold together
            if (k < 5'd26) begin
                code = 7'o40 + {2'b00, k};
            end else if (k == 5'd26) begin
                code = 7'o135;
            end else begin
                code = 7'o72 + {2'b00, k} - 7'd27;
            end
        end else begin
            case (cp)
                16'h000D: code = 7'o174;
                16'h00AC: code = 7'o123;
                16'h00B0: code = 7'o136;
                16'h00D7: code = 7'o24;
                16'h00F7: code = 7'o124;
                16'h2015: code = 7'o131;
                16'h2018: code = 7'o32;
                16'h2019: code = 7'o33;
                16'h2032: code = 7'o137;
                16'h203E: code = 7'o115;
                16'h212F: code = 7'o20;
                16'h2191: code = 7'o21;
                16'h2227: code = 7'o121;
                16'h2228: code = 7'o120;
                16'h2260: code = 7'o34;
                16'h2261: code = 7'o125;
                16'h2264: code = 7'o116;
                16'h2265: code = 7'o117;
                16'h2283: code = 7'o122;
                16'h25C7: code = 7'o127;
                16'h25CA: code = 7'o127;
                default:  code = GOST_UNKNOWN;
            endcase
        end
        return code;
    endfunction

    // odd parity in bit 7
    function automatic logic [7:0] with_parity(input logic [6:0] code);
        return {~(^code), code};
    endfunction

endpackage

[hw/rtl/ttp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_in_if / ttp_out_if: valid/ready channels
// Source words (action, byte) and tape words (frame, repeat, last).
// ----------------------------------------------------------------------------
interface ttp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] source_byte;

    modport source (output valid, output action, output source_byte, input ready);
    modport sink   (input valid, input action, input source_byte, output ready);
endinterface

interface ttp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame;
    logic [6:0] repeat_res;
    logic       last;

    modport source (output valid, output frame, output repeat_res, output last, input ready);
    modport sink   (input valid, input frame, input repeat_res, input last, output ready);
endinterface

[hw/rtl/ttp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_front: reader front end
// Accepts source words, decodes utf-8, tracks reader mode and card column and
// queues run or end-of-deck commands for the back end.
// ----------------------------------------------------------------------------
module ttp_front
    import ttp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ttp_in_if.sink        text,
    input  logic          q_full,
    output logic          q_push,
    output cmd_t          q_cmd
);

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_RUN  = 5'b00010,
        MODE_CARD = 5'b00100,
        MODE_SKIP = 5'b01000,
        MODE_TAIL = 5'b10000
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [COL_W-1:0] column_reg, column_next;
    logic [7:0]       lead_byte_reg, lead_byte_next;
    logic [7:0]       second_byte_reg, second_byte_next;
    logic [1:0]       pending_reg, pending_next;

    logic             accept;
    logic             active;
    logic             cp_valid;
    logic [15:0]      cp;
    logic [COL_W:0]   col_inc;
    cmd_t             char_cmd;
    action_t          act;

    assign text.ready = !q_full;
    assign accept     = text.valid && !q_full;
    assign act        = action_t'(text.action);
    assign active     = (mode_reg == MODE_RUN) || (mode_reg == MODE_CARD)
                        || (mode_reg == MODE_SKIP);
    assign col_inc    = {1'b0, column_reg} + 1'b1;

    // utf-8 decode of the current byte against held bytes
    always_comb
    begin
        lead_byte_next   = lead_byte_reg;
        second_byte_next = second_byte_reg;
        pending_next     = pending_reg;
        cp_valid         = 1'b0;
        cp               = {8'h00, text.source_byte};
        case (pending_reg)
            2'd0:
            begin
                if (!text.source_byte[7]) begin
                    cp_valid = 1'b1;
                end else begin
                    lead_byte_next = text.source_byte;
                    pending_next   = 2'd1;
                end
            end
            2'd1:
            begin
                if (!lead_byte_reg[5]) begin
                    pending_next = 2'd0;
                    cp_valid     = 1'b1;
                    cp           = {5'b0, lead_byte_reg[4:0], text.source_byte[5:0]};
                end else begin
                    second_byte_next = text.source_byte;
                    pending_next     = 2'd2;
                end
            end
            default:
            begin
                pending_next = 2'd0;
                cp = {lead_byte_reg[3:0], second_byte_reg[5:0], text.source_byte[5:0]};
                // byte order mark is dropped
                cp_valid = !(lead_byte_reg == 8'hEF && second_byte_reg == 8'hBB
                             && text.source_byte == 8'hBF);
            end
        endcase
    end

    assign char_cmd = '{deck: 1'b0, frame: with_parity(to_gost(cp)), rep: 7'd1};

    // action and mode handling
    always_comb
    begin
        mode_t            m_next;
        logic [COL_W-1:0] c_next;
        logic             push;
        cmd_t             cmd;
        m_next = mode_reg;
        c_next = column_reg;
        push   = 1'b0;
        cmd    = '{deck: 1'b0, frame: FRAME_BLANK, rep: 7'd1};
        if (!active && mode_reg != MODE_TAIL) begin
            m_next = MODE_IDLE;
        end
        unique case (act)
            ACT_MOTOR_ON:
            begin
                m_next = MODE_RUN;
                c_next = '0;
                push   = 1'b1;
            end
            ACT_MOTOR_OFF:
            begin
                m_next = MODE_IDLE;
                c_next = '0;
            end
            ACT_END:
            begin
                if (active) begin
                    push   = 1'b1;
                    m_next = MODE_TAIL;
                    c_next = '0;
                end
            end
            ACT_BYTE:
            begin
                if (active) begin
                    if (cp_valid) begin
                        unique case (mode_reg)
                            MODE_RUN:
                            begin
                                if (cp == 16'h000C) begin
                                    m_next = MODE_CARD;
                                    c_next = '0;
                                end else if (cp != 16'h000A) begin
                                    push = 1'b1;
                                    cmd  = char_cmd;
                                end
                            end
                            MODE_CARD:
                            begin
                                if (cp == 16'h000A) begin
                                    // zero-fill rest of card
                                    if (column_reg < COL_W'(CARD_COLUMNS)) begin
                                        push = 1'b1;
                                        cmd  = '{deck: 1'b0, frame: FRAME_BLANK,
                                                 rep: COL_W'(CARD_COLUMNS) - column_reg};
                                    end
                                    c_next = '0;
                                end else if (cp == 16'h000C) begin
                                    push   = 1'b1;
                                    cmd    = '{deck: 1'b1, frame: FRAME_DECK, rep: 7'd1};
                                    m_next = MODE_RUN;
                                    c_next = '0;
                                end else begin
                                    push = 1'b1;
                                    cmd  = char_cmd;
                                    if (col_inc >= (COL_W + 1)'(CARD_COLUMNS)) begin
                                        m_next = MODE_SKIP;
                                        c_next = '0;
                                    end else begin
                                        c_next = col_inc[COL_W-1:0];
                                    end
                                end
                            end
                            default:
                            begin
                                // skipping an over-long line
                                if (cp == 16'h000A) begin
                                    m_next = MODE_CARD;
                                    c_next = '0;
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                m_next = mode_reg;
            end
        endcase
        mode_next   = m_next;
        column_next = c_next;
        q_push      = accept && push;
        q_cmd       = cmd;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg        <= MODE_IDLE;
            column_reg      <= '0;
            lead_byte_reg   <= '0;
            second_byte_reg <= '0;
            pending_reg     <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            column_reg <= column_next;
            if (act == ACT_BYTE && active) begin
                lead_byte_reg   <= lead_byte_next;
                second_byte_reg <= second_byte_next;
                pending_reg     <= pending_next;
            end else if (act == ACT_END && active) begin
                pending_reg <= 2'd0;
            end
        end
    end

endmodule

[hw/rtl/ttp_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_fifo: command queue
// Small show-ahead queue of commands between reader front and punch back end.
// ----------------------------------------------------------------------------
module ttp_fifo
    import ttp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full     = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/ttp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_back: punch back end
// Takes queued commands, expands the end-of-deck pattern into runs and holds
// each tape word in an output register.
// ----------------------------------------------------------------------------
module ttp_back
    import ttp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          head_cmd,
    input  logic          q_empty,
    output logic          q_pop,
    ttp_out_if.source     tape
);

    logic             out_valid_reg;
    logic [7:0]       frame_reg;
    logic [6:0]       rep_reg;
    logic             last_reg;

    logic             deck_busy_reg;
    logic             zero_phase_reg;
    logic [COL_W-1:0] pos_reg;

    logic             slot_free;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] zrun;
    logic [COL_W:0]   pos_step;

    assign tape.valid      = out_valid_reg;
    assign tape.frame      = frame_reg;
    assign tape.repeat_res = rep_reg;
    assign tape.last       = last_reg;

    assign slot_free = !out_valid_reg || tape.ready;
    assign q_pop     = slot_free && !deck_busy_reg && !q_empty;

    // columns after the current deck mark
    assign left     = COL_W'(CARD_COLUMNS - 1) - pos_reg;
    assign zrun     = (left > COL_W'(DECK_STRIDE - 1)) ? COL_W'(DECK_STRIDE - 1) : left;
    assign pos_step = {1'b0, pos_reg} + (COL_W + 1)'(DECK_STRIDE);

    // output word register
    always_ff @(posedge clk)
    begin
        if (slot_free) begin
            if (deck_busy_reg) begin
                if (zero_phase_reg) begin
                    frame_reg <= FRAME_BLANK;
                    rep_reg   <= zrun;
                    last_reg  <= (pos_step >= (COL_W + 1)'(CARD_COLUMNS));
                end else begin
                    frame_reg <= FRAME_DECK;
                    rep_reg   <= 7'd1;
                    last_reg  <= (left == '0);
                end
            end else if (!q_empty) begin
                frame_reg <= head_cmd.frame;
                rep_reg   <= head_cmd.rep;
                last_reg  <= !head_cmd.deck;
            end
        end
    end

    // control: output valid and deck walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            deck_busy_reg  <= 1'b0;
            zero_phase_reg <= 1'b0;
            pos_reg        <= '0;
        end else if (slot_free) begin
            if (deck_busy_reg) begin
                out_valid_reg <= 1'b1;
                if (zero_phase_reg) begin
                    if (pos_step >= (COL_W + 1)'(CARD_COLUMNS)) begin
                        deck_busy_reg <= 1'b0;
                    end else begin
                        pos_reg        <= pos_step[COL_W-1:0];
                        zero_phase_reg <= 1'b0;
                    end
                end else begin
                    if (left == '0) begin
                        deck_busy_reg <= 1'b0;
                    end else begin
                        zero_phase_reg <= 1'b1;
                    end
                end
            end else if (!q_empty) begin
                out_valid_reg <= 1'b1;
                if (head_cmd.deck) begin
                    deck_busy_reg  <= 1'b1;
                    zero_phase_reg <= 1'b1;
                    pos_reg        <= '0;
                end
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/text_to_punch_tape_frames.sv]
`timescale 1ns / 1ps
// a result word passes through the command queue and then the output register
// the front end takes one source word per cycle while the queue is not full
// an end-of-deck form feed is expanded at the back end into deck marks and blank
// runs; the four-entry command queue holds later commands meanwhile
// reset: rst_n is asynchronous, active low, and clears mode, column, utf-8
// state, the queue and the valid flag of the output register
// ----------------------------------------------------------------------------
// text_to_punch_tape_frames: utf-8 text to punched tape frame runs
// Reader front end feeds a command queue; the punch back end expands commands
// into frame/repeat words.
// ----------------------------------------------------------------------------
module text_to_punch_tape_frames
    import ttp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ttp_in_if.sink     text,
    ttp_out_if.source  tape
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_cmd;
    cmd_t head_cmd;

    // reader front end
    ttp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    // command queue
    ttp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // punch back end
    ttp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .tape     (tape)
    );

`ifndef SYNTHESIS
    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("command pushed into full queue");

    // no pop from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    // every tape word punches between one and a full card of frames
    assert property (@(posedge clk) disable iff (!rst_n)
        tape.valid |-> (tape.repeat_res != 7'd0
                        && tape.repeat_res <= 7'(CARD_COLUMNS)))
        else $error("tape word repeat out of range");
`endif

endmodule

[sim/tape_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_checker: tape word predictor and comparator
// Watches both channels of the text to tape frame generator, works out the
// tape words each accepted source word should cause, and compares every
// accepted tape word field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module tape_checker
    import ttp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ttp_in_if    text,
    ttp_out_if   tape,
    output int   mismatches,
    output int   words_due
);

    // reader modes
    typedef enum logic [2:0] {
        RD_IDLE = 3'd0,
        RD_RUN  = 3'd1,
        RD_CARD = 3'd2,
        RD_SKIP = 3'd3,
        RD_TAIL = 3'd4
    } reader_t;

    typedef struct packed {
        logic [7:0] frame;
        logic [6:0] rep;
        logic       last;
    } tape_word_t;

    localparam logic [15:0] CP_NEWLINE   = 16'h000A;
    localparam logic [15:0] CP_FORM_FEED = 16'h000C;
    localparam logic [7:0]  BOM_0        = 8'hEF;
    localparam logic [7:0]  BOM_1        = 8'hBB;
    localparam logic [7:0]  BOM_2        = 8'hBF;

    // gost codes of the printable latin range 0x20..0x7f
    localparam logic [6:0] LATIN_GOST [0:95] = '{
        7'o17,  7'o133, 7'o134, 7'o34,  7'o127, 7'o126, 7'o121, 7'o33,
        7'o22,  7'o23,  7'o31,  7'o12,  7'o15,  7'o13,  7'o16,  7'o14,
        7'o00,  7'o01,  7'o02,  7'o03,  7'o04,  7'o05,  7'o06,  7'o07,
        7'o10,  7'o11,  7'o37,  7'o26,  7'o35,  7'o25,  7'o36,  7'o136,
        7'o21,  7'o40,  7'o42,  7'o61,  7'o77,  7'o45,  7'o100, 7'o101,
        7'o55,  7'o102, 7'o103, 7'o52,  7'o104, 7'o54,  7'o105, 7'o56,
        7'o60,  7'o106, 7'o107, 7'o110, 7'o62,  7'o111, 7'o112, 7'o113,
        7'o65,  7'o63,  7'o114, 7'o27,  7'o17,  7'o30,  7'o115, 7'o132,
        7'o32,  7'o40,  7'o42,  7'o61,  7'o77,  7'o45,  7'o100, 7'o101,
        7'o55,  7'o102, 7'o103, 7'o52,  7'o104, 7'o54,  7'o105, 7'o56,
        7'o60,  7'o106, 7'o107, 7'o110, 7'o62,  7'o111, 7'o112, 7'o113,
        7'o65,  7'o63,  7'o114, 7'o17,  7'o130, 7'o17,  7'o123, 7'o17
    };

    // predicted reader state
    reader_t     mode;
    logic [6:0]  column;
    logic [7:0]  lead;
    logic [7:0]  second;
    logic [1:0]  held;
    int          errors_seen;
    tape_word_t  tape_words_due [$];

    // code point to 7-bit gost code
    function automatic logic [6:0] gost_code(input logic [15:0] cp);
        logic [15:0] off;
        logic [4:0]  k;
        off = cp - 16'h0410;
        k   = off[4:0];
        if (cp >= 16'h0020 && cp <= 16'h007F)
        begin
            return LATIN_GOST[cp - 16'h0020];
        end
        // both cyrillic cases share one code
        if (cp >= 16'h0410 && cp <= 16'h044F)
        begin
            if (k < 5'd26)
            begin
                return 7'o40 + {2'b00, k};
            end
            if (k == 5'd26)
            begin
                return 7'o135;
            end
            return 7'o72 + {2'b00, k} - 7'd27;
        end
        case (cp)
            16'h000D: return 7'o174;
            16'h00AC: return 7'o123;
            16'h00B0: return 7'o136;
            16'h00D7: return 7'o24;
            16'h00F7: return 7'o124;
            16'h2015: return 7'o131;
            16'h2018: return 7'o32;
            16'h2019: return 7'o33;
            16'h2032: return 7'o137;
            16'h203E: return 7'o115;
            16'h212F: return 7'o20;
            16'h2191: return 7'o21;
            16'h2227: return 7'o121;
            16'h2228: return 7'o120;
            16'h2260: return 7'o34;
            16'h2261: return 7'o125;
            16'h2264: return 7'o116;
            16'h2265: return 7'o117;
            16'h2283: return 7'o122;
            16'h25C7: return 7'o127;
            16'h25CA: return 7'o127;
            default:  return 7'o17;
        endcase
    endfunction

    // bit 7 makes the count of ones odd
    function automatic logic [7:0] odd_frame(input logic [6:0] code);
        logic even;
        even = ~(^code);
        return {even, code};
    endfunction

    task automatic queue_word(input logic [7:0] frame, input logic [6:0] rep);
        tape_word_t w;
        w.frame = frame;
        w.rep   = rep;
        w.last  = 1'b0;
        tape_words_due.push_back(w);
    endtask

    // utf-8 decoder, byte order mark dropped
    task automatic take_byte(input logic [7:0] b, output logic got, output logic [15:0] cp);
        got = 1'b0;
        cp  = 16'h0000;
        if (held == 2'd0)
        begin
            if (!b[7])
            begin
                cp  = {8'h00, b};
                got = 1'b1;
            end
            else
            begin
                lead = b;
                held = 2'd1;
            end
        end
        else if (held == 2'd1)
        begin
            if (!lead[5])
            begin
                held = 2'd0;
                cp   = {5'b00000, lead[4:0], b[5:0]};
                got  = 1'b1;
            end
            else
            begin
                second = b;
                held   = 2'd2;
            end
        end
        else
        begin
            held = 2'd0;
            if (!(lead == BOM_0 && second == BOM_1 && b == BOM_2))
            begin
                cp  = {lead[3:0], second[5:0], b[5:0]};
                got = 1'b1;
            end
        end
    endtask

    // one decoded character against the reader mode
    task automatic place_char(input logic [15:0] cp);
        int rest;
        int gap;
        case (mode)
            RD_RUN:
            begin
                if (cp == CP_FORM_FEED)
                begin
                    mode   = RD_CARD;
                    column = '0;
                end
                else if (cp != CP_NEWLINE)
                begin
                    queue_word(odd_frame(gost_code(cp)), 7'd1);
                end
            end
            RD_CARD:
            begin
                if (cp == CP_NEWLINE)
                begin
                    // blank out the rest of the card
                    rest = CARD_COLUMNS - int'(column);
                    if (rest > 0)
                    begin
                        queue_word(FRAME_BLANK, rest[6:0]);
                    end
                    column = '0;
                end
                else if (cp == CP_FORM_FEED)
                begin
                    // end-of-deck: mark every fifth column
                    for (int col = 0; col < CARD_COLUMNS; col += DECK_STRIDE)
                    begin
                        queue_word(FRAME_DECK, 7'd1);
                        gap = CARD_COLUMNS - col - 1;
                        if (gap > DECK_STRIDE - 1)
                        begin
                            gap = DECK_STRIDE - 1;
                        end
                        if (gap > 0)
                        begin
                            queue_word(FRAME_BLANK, gap[6:0]);
                        end
                    end
                    mode   = RD_RUN;
                    column = '0;
                end
                else
                begin
                    queue_word(odd_frame(gost_code(cp)), 7'd1);
                    column = column + 7'd1;
                    if (int'(column) >= CARD_COLUMNS)
                    begin
                        mode   = RD_SKIP;
                        column = '0;
                    end
                end
            end
            RD_SKIP:
            begin
                if (cp == CP_NEWLINE)
                begin
                    mode   = RD_CARD;
                    column = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // expected tape words of one source word
    task automatic predict_tape_words(input logic [1:0] act, input logic [7:0] b);
        int          first;
        logic        active;
        logic        got;
        logic [15:0] cp;
        first  = tape_words_due.size();
        active = (mode == RD_RUN) || (mode == RD_CARD) || (mode == RD_SKIP);
        case (act)
            ACT_MOTOR_ON:
            begin
                mode   = RD_RUN;
                column = '0;
                queue_word(FRAME_BLANK, 7'd1);
            end
            ACT_MOTOR_OFF:
            begin
                mode   = RD_IDLE;
                column = '0;
            end
            ACT_END:
            begin
                if (active)
                begin
                    queue_word(FRAME_BLANK, 7'd1);
                    mode   = RD_TAIL;
                    column = '0;
                    held   = 2'd0;
                end
            end
            default:
            begin
                if (active)
                begin
                    take_byte(b, got, cp);
                    if (got)
                    begin
                        place_char(cp);
                    end
                end
            end
        endcase
        if (tape_words_due.size() > first)
        begin
            tape_words_due[tape_words_due.size() - 1].last = 1'b1;
        end
    endtask

    // compare tape words, then predict from the source word of this edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        tape_word_t want;
        if (!rst_n)
        begin
            mode        = RD_IDLE;
            column      = '0;
            lead        = '0;
            second      = '0;
            held        = 2'd0;
            errors_seen = 0;
            tape_words_due.delete();
            mismatches <= 0;
            words_due  <= 0;
        end
        else
        begin
            if (tape.valid && tape.ready)
            begin
                if (tape_words_due.size() == 0)
                begin
                    $error("unexpected tape word: frame %h repeat %0d last %b",
                           tape.frame, tape.repeat_res, tape.last);
                    errors_seen++;
                end
                else
                begin
                    want = tape_words_due.pop_front();
                    if (tape.frame !== want.frame)
                    begin
                        $error("frame: expected %h, got %h", want.frame, tape.frame);
                        errors_seen++;
                    end
                    if (tape.repeat_res !== want.rep)
                    begin
                        $error("repeat_res: expected %0d, got %0d", want.rep, tape.repeat_res);
                        errors_seen++;
                    end
                    if (tape.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, tape.last);
                        errors_seen++;
                    end
                end
            end
            if (text.valid && text.ready)
            begin
                predict_tape_words(text.action, text.source_byte);
            end
            mismatches <= errors_seen;
            words_due  <= tape_words_due.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: text to punched tape frame generator
// Drives UTF-8 text, end-of-source and motor commands with random gaps and
// tape-side stalls: directed corner words first, then running text, card
// decks with over-long lines, early ends and noise. A checker beside the
// block predicts and compares every tape word.
// ----------------------------------------------------------------------------
module testbench;
    import ttp_pkg::*;

    localparam int          ITEM_TARGET    = 360;
    localparam int          CALM_ITEMS     = 60;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [15:0] CP_NEWLINE     = 16'h000A;
    localparam logic [15:0] CP_RETURN      = 16'h000D;
    localparam logic [15:0] CP_FORM_FEED   = 16'h000C;
    localparam logic [7:0]  BOM_0          = 8'hEF;
    localparam logic [7:0]  BOM_1          = 8'hBB;
    localparam logic [7:0]  BOM_2          = 8'hBF;

    // code points with their own table entries
    localparam logic [15:0] SPECIAL_CPS [0:20] = '{
        16'h000D, 16'h00AC, 16'h00B0, 16'h00D7, 16'h00F7, 16'h2015, 16'h2018,
        16'h2019, 16'h2032, 16'h203E, 16'h212F, 16'h2191, 16'h2227, 16'h2228,
        16'h2260, 16'h2261, 16'h2264, 16'h2265, 16'h2283, 16'h25C7, 16'h25CA
    };

    logic clk;
    logic rst_n;
    bit   gaps_on;
    bit   stalls_on;
    bit   reader_on;
    bit   long_done;
    int   words_counted;
    int   idle_cycles;
    int   mismatches;
    int   words_due;

    ttp_in_if  text_ch ();
    ttp_out_if tape_ch ();

    text_to_punch_tape_frames dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .tape  (tape_ch)
    );

    tape_checker tape_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text_ch),
        .tape       (tape_ch),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_ch.valid && text_ch.ready) || (tape_ch.valid && tape_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // tape side ready with random stall bursts
    initial
    begin
        tape_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                tape_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            tape_ch.ready <= 1'b1;
        end
    end

    // one source word, held until taken
    task automatic send_word(input action_t act, input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.action      <= act;
        text_ch.source_byte <= b;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
        // words sent while the reader is stopped do not count
        if (act == ACT_MOTOR_ON || reader_on)
        begin
            words_counted++;
        end
        if (act == ACT_MOTOR_ON)
        begin
            reader_on = 1'b1;
        end
        else if (act != ACT_BYTE)
        begin
            reader_on = 1'b0;
        end
    endtask

    // utf-8 encode, continuation marks and spare lead bits random
    task automatic send_char(input logic [15:0] cp);
        logic [1:0] mark;
        mark = 2'($urandom_range(0, 3));
        if (cp < 16'h0080)
        begin
            send_word(ACT_BYTE, cp[7:0]);
        end
        else if (cp < 16'h0800)
        begin
            send_word(ACT_BYTE, {1'b1, mark[0], 1'b0, cp[10:6]});
            send_word(ACT_BYTE, {mark, cp[5:0]});
        end
        else
        begin
            send_word(ACT_BYTE, {1'b1, mark[0], 1'b1, mark[1], cp[15:12]});
            send_word(ACT_BYTE, {2'(1 + $urandom_range(0, 2)), cp[11:6]});
            send_word(ACT_BYTE, {mark, cp[5:0]});
        end
    endtask

    task automatic send_bom();
        send_word(ACT_BYTE, BOM_0);
        send_word(ACT_BYTE, BOM_1);
        send_word(ACT_BYTE, BOM_2);
    endtask

    // random text character, never a newline or form feed
    function automatic logic [15:0] pick_char();
        int          roll;
        logic [15:0] cp;
        roll = $urandom_range(0, 19);
        if (roll < 10)
        begin
            cp = 16'($urandom_range(16'h0020, 16'h007F));
        end
        else if (roll < 13)
        begin
            cp = 16'($urandom_range(16'h0410, 16'h044F));
        end
        else if (roll < 16)
        begin
            cp = SPECIAL_CPS[$urandom_range(0, 20)];
        end
        else if (roll == 16)
        begin
            cp = 16'($urandom_range(16'h0000, 16'h001F));
            if (cp == CP_NEWLINE || cp == CP_FORM_FEED)
            begin
                cp = CP_RETURN;
            end
        end
        else if (roll < 19)
        begin
            cp = 16'($urandom_range(16'h0080, 16'h07FF));
        end
        else
        begin
            cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        end
        return cp;
    endfunction

    // card mode: short lines, maybe one over-long line, then end of deck
    task automatic punch_card_deck(input bit with_long_line);
        int lines;
        int len;
        send_word(ACT_MOTOR_ON, 8'($urandom));
        send_char(CP_FORM_FEED);
        lines = $urandom_range(1, 4);
        for (int ln = 0; ln < lines; ln++)
        begin
            len = $urandom_range(0, 12);
            repeat (len) send_char(pick_char());
            send_char(CP_NEWLINE);
        end
        if (with_long_line)
        begin
            // one short of full, exactly full, or past the end
            case ($urandom_range(0, 2))
                0:       len = CARD_COLUMNS - 1;
                1:       len = CARD_COLUMNS;
                default: len = CARD_COLUMNS + $urandom_range(2, 6);
            endcase
            for (int i = 0; i < len; i++)
            begin
                // a form feed in the dropped part is ignored
                if (i == CARD_COLUMNS + 1)
                begin
                    send_char(CP_FORM_FEED);
                end
                else
                begin
                    send_char(pick_char());
                end
            end
            send_char(CP_NEWLINE);
        end
        // sometimes the deck ends in the middle of a card
        if ($urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, 5)) send_char(pick_char());
        end
        send_char(CP_FORM_FEED);
    endtask

    // stimulus and verdict
    initial
    begin
        int chars;
        rst_n = 1'b0;
        text_ch.valid       <= 1'b0;
        text_ch.action      <= ACT_BYTE;
        text_ch.source_byte <= 8'h00;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        reader_on     = 1'b0;
        long_done     = 1'b0;
        words_counted = 0;
        idle_cycles   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored words while idle, decoder corners, one card
        send_word(ACT_BYTE, 8'h41);
        send_word(ACT_END, 8'h00);
        send_word(ACT_MOTOR_ON, 8'hFF);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'h7F);
        send_word(ACT_BYTE, 8'h0D);
        send_word(ACT_BYTE, 8'h0A);
        send_bom();
        send_word(ACT_BYTE, 8'hD0);
        send_word(ACT_BYTE, 8'h90);
        send_word(ACT_BYTE, 8'hD1);
        send_word(ACT_BYTE, 8'h8F);
        send_word(ACT_BYTE, 8'hE2);
        send_word(ACT_BYTE, 8'h80);
        send_word(ACT_BYTE, 8'h95);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, 8'h0C);
        send_word(ACT_BYTE, 8'h5A);
        send_word(ACT_BYTE, 8'h0A);
        send_word(ACT_BYTE, 8'h0C);
        send_word(ACT_END, 8'hAA);
        send_word(ACT_BYTE, 8'h55);
        send_word(ACT_MOTOR_OFF, 8'h00);

        // random scenarios, calm at the end
        while (words_counted < ITEM_TARGET)
        begin
            if (words_counted >= ITEM_TARGET - CALM_ITEMS)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // running text
                    if (!reader_on || $urandom_range(0, 3) == 0)
                    begin
                        send_word(ACT_MOTOR_ON, 8'($urandom));
                    end
                    chars = $urandom_range(1, 12);
                    repeat (chars)
                    begin
                        case ($urandom_range(0, 19))
                            0, 1:    send_char(CP_NEWLINE);
                            2:       send_bom();
                            default: send_char(pick_char());
                        endcase
                    end
                end
                4, 5, 6:
                begin
                    if (!long_done || $urandom_range(0, 7) == 0)
                    begin
                        long_done = 1'b1;
                        punch_card_deck(1'b1);
                    end
                    else
                    begin
                        punch_card_deck(1'b0);
                    end
                end
                7:
                begin
                    // end of source, maybe mid-sequence, then tail noise
                    if (!reader_on)
                    begin
                        send_word(ACT_MOTOR_ON, 8'($urandom));
                    end
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_word(ACT_BYTE, {2'b11, 6'($urandom)});
                    end
                    send_word(ACT_END, 8'($urandom));
                    repeat ($urandom_range(0, 3)) send_word(ACT_BYTE, 8'($urandom));
                    send_word(ACT_END, 8'($urandom));
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_word(ACT_MOTOR_ON, 8'($urandom));
                    end
                end
                8:
                begin
                    // motor off, idle noise, restart
                    send_word(ACT_MOTOR_OFF, 8'($urandom));
                    repeat ($urandom_range(0, 3)) send_word(ACT_BYTE, 8'($urandom));
                    send_word(ACT_END, 8'($urandom));
                    send_word(ACT_MOTOR_ON, 8'($urandom));
                end
                default:
                begin
                    // raw byte noise while reading
                    if (!reader_on)
                    begin
                        send_word(ACT_MOTOR_ON, 8'($urandom));
                    end
                    repeat ($urandom_range(1, 6)) send_word(ACT_BYTE, 8'($urandom));
                end
            endcase
        end

        // drain
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
